// ===== hw/rtl/yaz0_pkg.sv =====
`timescale 1ns / 1ps
package yaz0_pkg;
   localparam int unsigned HIST_AW = 12;

   // parse phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_REF2   = 2'd2;
   localparam logic [1:0] PH_REF3   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_BAD_REF  = 2'd2;

   // magic byte for a header position
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      case (idx)
         2'd0: magic_byte = 8'h59;
         2'd1: magic_byte = 8'h61;
         2'd2: magic_byte = 8'h7a;
         default: magic_byte = 8'h30;
      endcase
   endfunction
endpackage

// ===== hw/rtl/yaz0_ram.sv =====
`timescale 1ns / 1ps
module yaz0_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/yaz0_stream_decompressor.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                              Direction
// request   req_valid/ready, req_in_byte, req_start_of_file    in
// response  rsp_valid/ready, rsp_out_word, rsp_byte_count,     out
//           rsp_last_of_run, rsp_file_done, rsp_status
//
// Header, flag and literal requests are handled when accepted, plus output hand-off.
// A back-reference of length L copies through the 4096x8 history RAM (one
// write and one registered read port): after accept the read is issued in
// S_READ, then S_COPY writes each byte and advances, waiting while the response
// side stalls; a source byte that was just written is read again via S_READ.
// Reset is synchronous; the history RAM is not cleared.
// While a copy runs, or a response is held, req_ready stays low.
module yaz0_stream_decompressor #(
   parameter int OUT_LANES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_word,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_of_run,
   output logic        rsp_file_done,
   output logic [1:0]  rsp_status
);
   import yaz0_pkg::*;

   localparam logic [3:0] LANES = 4'(OUT_LANES);

   // control states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;  // copy: read issued, wait data
   localparam logic [1:0] S_COPY = 2'd2;  // copy: data valid

   logic [1:0]  state_ff, state_in;
   logic [11:0] hptr_ff, hptr_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] target_ff, target_in;
   logic [7:0]  flags_ff, flags_in;
   logic [3:0]  fidx_ff, fidx_in;
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  hidx_ff, hidx_in;
   logic [7:0]  pf_ff, pf_in;
   logic [7:0]  ps_ff, ps_in;
   logic        fin_ff, fin_in;
   // copy engine
   logic [8:0]  rem_ff, rem_in;
   logic [32:0] src_ff, src_in;
   logic        cstat_ff, cstat_in;
   // word assembly
   logic [63:0] word_ff, word_in;
   logic [3:0]  cnt_ff, cnt_in;
   // output register
   logic        ov_ff, ov_in;
   logic [63:0] ow_ff, ow_in;
   logic [3:0]  oc_ff, oc_in;
   logic        ol_ff, ol_in, od_ff, od_in;
   logic [1:0]  os_ff, os_in;

   logic        wr_en;
   logic [11:0] wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;

   yaz0_ram #(.WIDTH(8), .DEPTH(2 ** HIST_AW)) u_hist (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic        out_free;
   assign out_free  = !ov_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;

   assign rsp_valid       = ov_ff;
   assign rsp_out_word    = ow_ff;
   assign rsp_byte_count  = oc_ff;
   assign rsp_last_of_run = ol_ff;
   assign rsp_file_done   = od_ff;
   assign rsp_status      = os_ff;

   // main next-state logic
   always_comb begin
      logic        acc, sof, push, last, fin_t, bad;
      logic [7:0]  b, pbyte;
      logic [1:0]  ph;
      logic [3:0]  hi, fi, nc;
      logic [31:0] tg, pc, avail;
      logic [11:0] hp;
      logic [63:0] wd;
      logic [8:0]  len;
      logic [12:0] ref_off;
      state_in = state_ff; hptr_in = hptr_ff; prod_in = prod_ff;
      target_in = target_ff; flags_in = flags_ff; fidx_in = fidx_ff;
      phase_in = phase_ff; hidx_in = hidx_ff; pf_in = pf_ff; ps_in = ps_ff;
      fin_in = fin_ff;
      rem_in = rem_ff; src_in = src_ff; cstat_in = cstat_ff;
      word_in = word_ff; cnt_in = cnt_ff;
      ov_in = ov_ff && !rsp_ready; ow_in = ow_ff; oc_in = oc_ff;
      ol_in = ol_ff; od_in = od_ff; os_in = os_ff;
      wr_en = 1'b0; wr_addr = hptr_ff; wr_data = 8'h00;
      rd_addr = src_ff[11:0];
      acc = req_valid && req_ready;
      b = req_in_byte; sof = req_start_of_file;
      pbyte = 8'h00; push = 1'b0; last = 1'b0; bad = 1'b0;
      len = 9'd0; ref_off = 13'd0; avail = 32'd0;
      ph = phase_ff; hi = hidx_ff; fi = fidx_ff; tg = target_ff; pc = prod_ff;
      hp = hptr_ff; fin_t = fin_ff; wd = 64'd0; nc = 4'd0;

      if (acc) begin
         if (sof) begin
            ph = PH_HEADER; hi = 4'd0; fi = 4'd8; tg = 32'd0; pc = 32'd0;
            hp = 12'd0; fin_t = 1'b0; flags_in = 8'h00; pf_in = 8'h00;
            ps_in = 8'h00;
         end
         phase_in = ph; hidx_in = hi; fidx_in = fi; target_in = tg;
         prod_in = pc; hptr_in = hp; fin_in = fin_t;
         if (!fin_t) begin
            case (ph)
               PH_HEADER: begin
                  if (hi < 4'd4 && b != magic_byte(hi[1:0])) begin
                     bad = 1'b1; fin_in = 1'b1;
                     ov_in = 1'b1; ow_in = 64'd0; oc_in = 4'd0; ol_in = 1'b1;
                     od_in = 1'b0; os_in = ST_BAD_MAGIC;
                  end else begin
                     if (hi >= 4'd4 && hi < 4'd8) target_in = {tg[23:0], b};
                     if (hi == 4'd15) begin
                        phase_in = PH_DATA;
                        if (tg == 32'd0) begin
                           fin_in = 1'b1;
                           ov_in = 1'b1; ow_in = 64'd0; oc_in = 4'd0;
                           ol_in = 1'b1; od_in = 1'b1; os_in = ST_OK;
                        end
                     end else begin
                        hidx_in = hi + 4'd1;
                     end
                  end
               end
               PH_DATA: begin
                  if (fi >= 4'd8) begin
                     flags_in = b; fidx_in = 4'd0;
                  end else begin
                     fidx_in = fi + 4'd1;
                     if (flags_ff[3'd7 - fi[2:0]]) begin
                        // literal: one byte, one response
                        wr_en = 1'b1; wr_addr = hp; wr_data = b;
                        hptr_in = hp + 12'd1; prod_in = pc + 32'd1;
                        ov_in = 1'b1; ow_in = {56'd0, b}; oc_in = 4'd1;
                        ol_in = 1'b1; os_in = ST_OK;
                        od_in = (pc + 32'd1 == tg);
                        fin_in = (pc + 32'd1 == tg);
                     end else begin
                        pf_in = b; phase_in = PH_REF2;
                     end
                  end
               end
               default: begin
                  // PH_REF2 or PH_REF3
                  ref_off = {1'b0, pf_ff[3:0], (ph == PH_REF2) ? b : ps_ff}
                            + 13'd1;
                  if (ph == PH_REF2) ps_in = b;
                  if (ph == PH_REF2 && pf_ff[7:4] == 4'd0) begin
                     phase_in = PH_REF3;
                  end else begin
                     phase_in = PH_DATA;
                     len = (ph == PH_REF2) ? {5'd0, pf_ff[7:4]} + 9'd2
                                           : {1'b0, b} + 9'd18;
                     avail = tg - pc;
                     if ({23'd0, len} > avail) len = avail[8:0];
                     src_in = {1'b0, pc} - {20'd0, ref_off};
                     cstat_in = src_in[32];
                     rem_in = len;
                     word_in = 64'd0; cnt_in = 4'd0;
                     state_in = (len == 9'd0) ? S_IDLE : S_READ;
                  end
               end
            endcase
         end
      end

      // copy engine: issue the read, then write and advance
      if (state_ff == S_READ) begin
         rd_addr = src_ff[11:0];
         state_in = S_COPY;
      end else if (state_ff == S_COPY && out_free) begin
         pbyte = src_ff[32] ? 8'h00 : rd_data;
         wr_en = 1'b1; wr_addr = hptr_ff; wr_data = pbyte;
         hptr_in = hptr_ff + 12'd1;
         prod_in = prod_ff + 32'd1;
         src_in = src_ff + 33'd1;
         rem_in = rem_ff - 9'd1;
         wd = word_ff | ({56'd0, pbyte} << {cnt_ff[2:0], 3'b000});
         nc = cnt_ff + 4'd1;
         last = (rem_ff == 9'd1);
         push = (nc >= LANES) || last;
         if (prod_ff + 32'd1 == target_ff) fin_in = 1'b1;
         if (push) begin
            ov_in = 1'b1; ow_in = wd; oc_in = nc; ol_in = last;
            od_in = last && (fin_ff || prod_ff + 32'd1 == target_ff);
            os_in = cstat_ff ? ST_BAD_REF : ST_OK;
            word_in = 64'd0; cnt_in = 4'd0;
         end else begin
            word_in = wd; cnt_in = nc;
         end
         if (last) begin
            state_in = S_IDLE;
         end else begin
            // if the next source is the byte written this cycle: read it again next cycle
            rd_addr = src_in[11:0];
            state_in = (src_in[11:0] == hptr_ff) ? S_READ : S_COPY;
            if (src_in[11:0] == hptr_ff) rd_addr = src_in[11:0];
         end
      end else if (state_ff == S_COPY) begin
         rd_addr = src_ff[11:0];
      end
      if (bad) begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; hptr_ff <= 12'd0; prod_ff <= 32'd0;
         target_ff <= 32'd0; flags_ff <= 8'h00; fidx_ff <= 4'd8;
         phase_ff <= PH_HEADER; hidx_ff <= 4'd0; pf_ff <= 8'h00;
         ps_ff <= 8'h00;
         fin_ff <= 1'b0; ov_ff <= 1'b0; cnt_ff <= 4'd0;
      end else begin
         state_ff <= state_in; hptr_ff <= hptr_in; prod_ff <= prod_in;
         target_ff <= target_in; flags_ff <= flags_in; fidx_ff <= fidx_in;
         phase_ff <= phase_in; hidx_ff <= hidx_in; pf_ff <= pf_in;
         ps_ff <= ps_in;
         fin_ff <= fin_in; ov_ff <= ov_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; src_ff <= src_in; cstat_ff <= cstat_in;
      word_ff <= word_in;
      ow_ff <= ow_in; oc_ff <= oc_in; ol_ff <= ol_in; od_ff <= od_in;
      os_ff <= os_in;
   end
endmodule
